FILE: sv/mcdt_pkg.sv
// Shared types and constants for the mouse click and drag tracker.
// Holds the event codes, the input kinds, the controller states and the
// command and status bundles. It depends on nothing else.
`default_nettype none

package mcdt_pkg;

    // Default number of tracked buttons.
    localparam int NUM_BUTTONS_DEF = 3;

    typedef enum logic [1:0] {
        KIND_BUTTON = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_WHEEL  = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        EV_PRESSED    = 3'd0,
        EV_RELEASED   = 3'd1,
        EV_CLICKED    = 3'd2,
        EV_DRAG_END   = 3'd3,
        EV_MOVED      = 3'd4,
        EV_DRAG_BEGIN = 3'd5,
        EV_DRAGGED    = 3'd6,
        EV_WHEEL      = 3'd7
    } event_code_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_DECODE  = 2'd1,
        ST_RELEASE = 2'd2,
        ST_SCAN    = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        BSEL_ZERO = 2'd0,
        BSEL_ITEM = 2'd1,
        BSEL_SCAN = 2'd2
    } btn_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load;
        logic        snapshot;
        logic        emit;
        event_code_t emit_code;
        btn_sel_t    emit_btn;
        logic        emit_wheel;
        logic        emit_last;
        logic        set_held;
        logic        clr_held;
        logic        clr_drag_item;
        logic        set_drag_scan;
        logic        upd_pos;
        logic        idx_clr;
        logic        idx_inc;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  btn_ok;
        logic  pressed;
        logic  held_bit;
        logic  drag_bit;
        logic  pos_same;
        logic  produce_any;
        logic  scan_produce;
        logic  scan_drag;
        logic  scan_tail_none;
        logic  slot_free;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/mcdt_ctrl.sv
// Controller state machine of the mouse click and drag tracker.
// Sequences the result beats of one item; uses mcdt_pkg.
`default_nettype none

module mcdt_ctrl
    import mcdt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.kind)
                    KIND_TICK:
                    begin
                        state_next = ST_IDLE;
                    end
                    KIND_WHEEL:
                    begin
                        if (sts.slot_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_BUTTON:
                    begin
                        if (!sts.btn_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (sts.held_bit != sts.pressed)
                        begin
                            if (sts.slot_free)
                            begin
                                state_next = sts.pressed ? ST_IDLE : ST_RELEASE;
                            end
                        end
                        else
                        begin
                            state_next = sts.pressed ? ST_IDLE : ST_RELEASE;
                        end
                    end
                    KIND_MOVE:
                    begin
                        if (sts.pos_same)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (sts.slot_free)
                        begin
                            state_next = sts.produce_any ? ST_SCAN : ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RELEASE:
            begin
                if (sts.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_produce && sts.slot_free && sts.scan_tail_none)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                case (sts.kind)
                    KIND_TICK:
                    begin
                        cmd.snapshot = 1'b1;
                    end
                    KIND_WHEEL:
                    begin
                        cmd.emit       = sts.slot_free;
                        cmd.emit_code  = EV_WHEEL;
                        cmd.emit_btn   = BSEL_ZERO;
                        cmd.emit_wheel = 1'b1;
                        cmd.emit_last  = 1'b1;
                    end
                    KIND_BUTTON:
                    begin
                        if (sts.btn_ok && (sts.held_bit != sts.pressed) && sts.slot_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_code = sts.pressed ? EV_PRESSED : EV_RELEASED;
                            cmd.emit_btn  = BSEL_ITEM;
                            cmd.emit_last = sts.pressed;
                            cmd.set_held  = sts.pressed;
                            cmd.clr_held  = !sts.pressed;
                        end
                    end
                    KIND_MOVE:
                    begin
                        if (!sts.pos_same && sts.slot_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_code = EV_MOVED;
                            cmd.emit_btn  = BSEL_ZERO;
                            cmd.emit_last = !sts.produce_any;
                            cmd.upd_pos   = 1'b1;
                            cmd.idx_clr   = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd = '0;
                    end
                endcase
            end
            ST_RELEASE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_code     = sts.drag_bit ? EV_DRAG_END : EV_CLICKED;
                    cmd.emit_btn      = BSEL_ITEM;
                    cmd.emit_last     = 1'b1;
                    cmd.clr_drag_item = sts.drag_bit;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_produce)
                begin
                    if (sts.slot_free)
                    begin
                        cmd.emit          = 1'b1;
                        cmd.emit_code     = sts.scan_drag ? EV_DRAGGED : EV_DRAG_BEGIN;
                        cmd.emit_btn      = BSEL_SCAN;
                        cmd.emit_last     = sts.scan_tail_none;
                        cmd.set_drag_scan = !sts.scan_drag;
                        cmd.idx_inc       = !sts.scan_tail_none;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/mcdt_dp.sv
// Datapath of the mouse click and drag tracker: item register, button and
// drag flags, pointer position, scan index and output register. Uses mcdt_pkg.
`default_nettype none

module mcdt_dp
    import mcdt_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 sts,
    input  wire logic [1:0]         kind,
    input  wire logic [2:0]         button_index,
    input  wire logic               is_pressed,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [7:0]  wheel_step,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              event_code,
    output logic [2:0]              event_button,
    output logic signed [15:0]      event_x,
    output logic signed [15:0]      event_y,
    output logic signed [7:0]       event_wheel,
    output logic                    last_of_run
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [3:0] NB4 = 4'(NUM_BUTTONS);
    localparam logic [NUM_BUTTONS-1:0] ONES = {NUM_BUTTONS{1'b1}};

    // Item held while it is worked on.
    kind_t              item_kind_reg;
    logic [2:0]         item_btn_reg;
    logic               item_pressed_reg;
    logic signed [15:0] item_x_reg;
    logic signed [15:0] item_y_reg;
    logic signed [7:0]  item_wheel_reg;

    // Tracker state.
    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic [NUM_BUTTONS-1:0] drag_reg, drag_next;
    logic [NUM_BUTTONS-1:0] before_reg, before_next;
    logic signed [15:0]     ptr_x_reg, ptr_x_next;
    logic signed [15:0]     ptr_y_reg, ptr_y_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;

    // Output register.
    logic               ov_reg, ov_next;
    logic [2:0]         oc_reg, ob_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic signed [7:0]  ow_reg;
    logic               ol_reg;

    logic [NUM_BUTTONS-1:0] btn_oh;
    logic [NUM_BUTTONS-1:0] idx_oh;
    logic [NUM_BUTTONS-1:0] above_mask;
    logic [NUM_BUTTONS-1:0] produce;
    logic                   slot_free;

    assign btn_oh     = NUM_BUTTONS'(1) << item_btn_reg;
    assign idx_oh     = NUM_BUTTONS'(1) << idx_reg;
    assign above_mask = (ONES << idx_reg) << 1;
    // A held button reports on a move unless its drag ended within this frame.
    assign produce    = held_reg & (drag_reg | ~before_reg);
    assign slot_free  = !ov_reg || !out_stall;

    always_comb
    begin
        sts.kind           = item_kind_reg;
        sts.btn_ok         = {1'b0, item_btn_reg} < NB4;
        sts.pressed        = item_pressed_reg;
        sts.held_bit       = |(held_reg & btn_oh);
        sts.drag_bit       = |(drag_reg & btn_oh);
        sts.pos_same       = (item_x_reg == ptr_x_reg) && (item_y_reg == ptr_y_reg);
        sts.produce_any    = |produce;
        sts.scan_produce   = |(produce & idx_oh);
        sts.scan_drag      = |(drag_reg & idx_oh);
        sts.scan_tail_none = ~|(produce & above_mask);
        sts.slot_free      = slot_free;
    end

    always_comb
    begin
        held_next   = held_reg;
        drag_next   = drag_reg;
        before_next = before_reg;
        ptr_x_next  = ptr_x_reg;
        ptr_y_next  = ptr_y_reg;
        idx_next    = idx_reg;
        if (cmd.set_held)
        begin
            held_next = held_reg | btn_oh;
        end
        if (cmd.clr_held)
        begin
            held_next = held_reg & ~btn_oh;
        end
        if (cmd.clr_drag_item)
        begin
            drag_next = drag_reg & ~btn_oh;
        end
        if (cmd.set_drag_scan)
        begin
            drag_next = drag_reg | idx_oh;
        end
        if (cmd.snapshot)
        begin
            before_next = drag_reg;
        end
        if (cmd.upd_pos)
        begin
            ptr_x_next = item_x_reg;
            ptr_y_next = item_y_reg;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.emit)
        begin
            ov_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            drag_reg   <= '0;
            before_reg <= '0;
            ptr_x_reg  <= '0;
            ptr_y_reg  <= '0;
            idx_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            held_reg   <= held_next;
            drag_reg   <= drag_next;
            before_reg <= before_next;
            ptr_x_reg  <= ptr_x_next;
            ptr_y_reg  <= ptr_y_next;
            idx_reg    <= idx_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_kind_reg    <= kind_t'(kind);
            item_btn_reg     <= button_index;
            item_pressed_reg <= is_pressed;
            item_x_reg       <= pos_x;
            item_y_reg       <= pos_y;
            item_wheel_reg   <= wheel_step;
        end
        if (cmd.emit)
        begin
            oc_reg <= cmd.emit_code;
            case (cmd.emit_btn)
                BSEL_ITEM: ob_reg <= item_btn_reg;
                BSEL_SCAN: ob_reg <= 3'(idx_reg);
                default:   ob_reg <= 3'd0;
            endcase
            ox_reg <= cmd.upd_pos ? item_x_reg : ptr_x_reg;
            oy_reg <= cmd.upd_pos ? item_y_reg : ptr_y_reg;
            ow_reg <= cmd.emit_wheel ? item_wheel_reg : 8'sd0;
            ol_reg <= cmd.emit_last;
        end
    end

    assign out_valid    = ov_reg;
    assign event_code   = oc_reg;
    assign event_button = ob_reg;
    assign event_x      = ox_reg;
    assign event_y      = oy_reg;
    assign event_wheel  = ow_reg;
    assign last_of_run  = ol_reg;

endmodule

`default_nettype wire

FILE: sv/mouse_click_drag_tracker.sv
// Mouse click and drag tracker, top level.
// Instantiates the controller mcdt_ctrl and the datapath mcdt_dp; uses mcdt_pkg.
//
// Usage: raw pointer events enter on the input channel (in_valid, in_stall) one
// beat per event. Each event yields zero to 1 + NUM_BUTTONS result beats on the
// output channel (out_valid, out_stall); last_of_run marks the final beat of an
// event, and events that yield nothing (frame ticks, ignored buttons, repeated
// presses, moves to the same spot) produce no beat at all.
// An accepted event beat is registered in the item register and decoded by
// the controller, and its first result beat is registered in the output
// register. A new event is taken only once the last one is through. A release
// needs a step of its own for the click or drag-end beat, and a move that
// reports on a held button runs a drag scan in the controller that visits one
// button per cycle up to the highest reporting one, waiting while output stalls.
// The output beat sits in an output register, so the next event is taken
// while a finished result still waits. When the receiver stalls, the
// controller holds its step until the output register frees up; the input
// side then stalls too.
// Reset clears the held buttons, drag flags, previous drag flags and the
// pointer position, and drops any pending output beat.
`default_nettype none

module mouse_click_drag_tracker
    import mcdt_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [2:0]         button_index,
    input  wire logic               is_pressed,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [7:0]  wheel_step,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              event_code,
    output logic [2:0]              event_button,
    output logic signed [15:0]      event_x,
    output logic signed [15:0]      event_y,
    output logic signed [7:0]       event_wheel,
    output logic                    last_of_run
);

    // Command and status bundles between the controller and the datapath.
    cmd_t    cmd;
    status_t sts;

    mcdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcdt_dp #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .button_index (button_index),
        .is_pressed   (is_pressed),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .wheel_step   (wheel_step),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .event_button (event_button),
        .event_x      (event_x),
        .event_y      (event_y),
        .event_wheel  (event_wheel),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
